>>> rtl/core/wbbc_pkg.sv
`timescale 1ns / 1ps

package wbbc_pkg;

  // Fixed field widths of the request and response beats.
  localparam int unsigned BLOCK_BITS     = 64;
  localparam int unsigned BLOCK_NUM_BITS = 16;
  localparam int unsigned CMD_W          = 2;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned DISK_W     = 17;
  localparam int unsigned ENTRIES_W  = 5;

  // Victim selection LFSR: 16-bit Galois, right shift.
  localparam int unsigned       LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  // Reset values of the configuration registers.
  localparam logic [DISK_W-1:0]    DISK_BLOCKS_RST = 17'h10000;
  localparam logic [ENTRIES_W-1:0] ENTRIES_RST     = 5'd16;
  localparam logic [LFSR_W-1:0]    LFSR_SEED_RST   = 16'd1;

  // Default cache geometry.
  localparam int unsigned NUM_ENTRIES_DEF = 16;

  // The fourth encoding is undefined and is answered with an error beat.
  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_UNDEF = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_READ = 2'd0,
    KIND_WB   = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISK_BLOCKS    = 2'd0,
    CFG_ENTRIES_IN_USE = 2'd1,
    CFG_LFSR_SEED      = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERROR,
    ST_LOOKUP,
    ST_MOD,
    ST_EVICT_CHK,
    ST_EVICT_OUT,
    ST_UPDATE,
    ST_READ_OUT,
    ST_FL_SCAN,
    ST_FL_OUT,
    ST_FL_DONE
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [BLOCK_NUM_BITS-1:0] block_num;
    logic [BLOCK_BITS-1:0]     wdata;
    logic [BLOCK_BITS-1:0]     disk_data;
  } req_t;

  typedef struct packed {
    kind_e                     kind;
    logic [BLOCK_NUM_BITS-1:0] out_block;
    logic [BLOCK_BITS-1:0]     out_data;
    logic                      hit;
    logic                      last;
  } rsp_t;

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] cur);
    logic [LFSR_W-1:0] nxt;
    nxt = cur >> 1;
    if (cur[0]) begin
      nxt = nxt ^ LFSR_TAPS;
    end
    return nxt;
  endfunction

endpackage

>>> rtl/core/write_back_block_cache.sv
// Fully associative write-back block cache; tags, valid and dirty bits sit in flip-flops
// for a parallel match, the block data in a one-port-write, one-port-read synchronous memory.
// A hit is answered from its entry; a miss fills the first empty entry in use if there is one,
// else a victim chosen by the LFSR (bit-serial remainder over its 16 bits by the entry count),
// and a dirty victim is written back first. One request at a time.
// Flush writes back and invalidates each dirty entry among the entries in use. Reset empties all.
`timescale 1ns / 1ps

module write_back_block_cache #(
  parameter int unsigned NUM_ENTRIES = wbbc_pkg::NUM_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  wbbc_pkg::req_t                      in_i,
  // Response channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output wbbc_pkg::rsp_t                      out_o,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wbbc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wbbc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import wbbc_pkg::*;

  // Entry index width, and the width of a count that can reach NUM_ENTRIES itself.
  localparam int unsigned IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned N_W   = $clog2(NUM_ENTRIES + 1);
  localparam int unsigned CNT_W = $clog2(LFSR_W);

  // ---------------------------------------------------------------------------------------
  // Configuration registers. The port is always ready; the user writes only while idle, which the
  // block does not enforce. Writing the seed also reloads the LFSR, with a zero seed taken as one.
  // ---------------------------------------------------------------------------------------
  logic [DISK_W-1:0]    disk_q;
  logic [ENTRIES_W-1:0] entries_q;
  logic [LFSR_W-1:0]    lfsr_q, lfsr_d;
  logic                 cfg_acc;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_q    <= DISK_BLOCKS_RST;
      entries_q <= ENTRIES_RST;
      lfsr_q    <= LFSR_SEED_RST;
    end else begin
      lfsr_q <= lfsr_d;
      if (cfg_acc) begin
        case (cfg_index_i)
          CFG_DISK_BLOCKS: begin
            disk_q <= cfg_data_i[DISK_W-1:0];
          end
          CFG_ENTRIES_IN_USE: begin
            entries_q <= cfg_data_i[ENTRIES_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Entries in use, clamped to the range one to NUM_ENTRIES.
  logic [N_W-1:0] n_c;

  always_comb begin
    if (entries_q == '0) begin
      n_c = N_W'(1);
    end else if (32'(entries_q) > NUM_ENTRIES) begin
      n_c = N_W'(NUM_ENTRIES);
    end else begin
      n_c = N_W'(entries_q);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Entry state. Tags, valid and dirty bits are flip-flops so that all tags are matched in
  // parallel; outside the match and the empty search they are read only at the working pointer.
  // ---------------------------------------------------------------------------------------
  logic [BLOCK_NUM_BITS-1:0] tag_q [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0]    valid_q, valid_d;
  logic [NUM_ENTRIES-1:0]    dirty_q, dirty_d;
  logic                      tag_we;

  // Block data memory: written and read at one address each per cycle, read data registered.
  logic [BLOCK_BITS-1:0] data_mem [NUM_ENTRIES];
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_raddr;
  logic [BLOCK_BITS-1:0] mem_wdata;
  logic [BLOCK_BITS-1:0] rdata_q;

  // Request held for the whole of its processing, and the controller state.
  state_e         state_q, state_d;
  req_t           req_q;
  logic [N_W-1:0] ptr_q, ptr_d;
  logic [IDX_W-1:0] pidx;
  logic           hit_q, hit_d;
  logic [N_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Response register: it parts the two channels.
  logic out_valid_q, out_valid_d;
  rsp_t out_q, out_d;
  logic out_free;
  logic emit;

  logic in_acc;
  logic in_err;

  assign pidx     = ptr_q[IDX_W-1:0];
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // A request is only taken in idle; the response register may still hold a beat then.
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Undefined command, or a read or write beyond the disk, gives a single error beat.
  assign in_err = (in_i.cmd == CMD_UNDEF) || (DISK_W'(in_i.block_num) >= disk_q);

  // ---------------------------------------------------------------------------------------
  // Tag match and first empty entry among the entries in use.
  // ---------------------------------------------------------------------------------------
  logic [NUM_ENTRIES-1:0] in_use;
  logic [NUM_ENTRIES-1:0] match;
  logic                   hit_found, empty_found;
  logic [IDX_W-1:0]       hit_idx, empty_idx;

  always_comb begin
    hit_found   = 1'b0;
    empty_found = 1'b0;
    hit_idx     = '0;
    empty_idx   = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      in_use[i] = (N_W'(i) < n_c);
      match[i]  = in_use[i] && valid_q[i] && (tag_q[i] == req_q.block_num);
    end
    // Walking downwards leaves the lowest index in place.
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_found = 1'b1;
        hit_idx   = IDX_W'(i);
      end
      if (in_use[i] && !valid_q[i]) begin
        empty_found = 1'b1;
        empty_idx   = IDX_W'(i);
      end
    end
  end

  // One step of the restoring remainder of the LFSR value by the entry count, MSB first.
  logic [N_W:0] trial;
  logic [N_W:0] n_ext;

  assign n_ext = {1'b0, n_c};
  assign trial = {rem_q, lfsr_q[(LFSR_W - 1) - 32'(cnt_q)]};

  always_comb begin
    if (trial >= n_ext) begin
      rem_d = N_W'(trial - n_ext);
    end else begin
      rem_d = N_W'(trial);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Next state.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.cmd == CMD_FLUSH) begin
            state_d = ST_FL_SCAN;
          end else if (in_err) begin
            state_d = ST_ERROR;
          end else begin
            state_d = ST_LOOKUP;
          end
        end
      end
      ST_ERROR, ST_READ_OUT, ST_UPDATE, ST_FL_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_LOOKUP: begin
        if (hit_found) begin
          state_d = (req_q.cmd == CMD_READ) ? ST_READ_OUT : ST_UPDATE;
        end else if (empty_found) begin
          state_d = ST_EVICT_CHK;
        end else begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (cnt_q == CNT_W'(LFSR_W - 1)) begin
          state_d = ST_EVICT_CHK;
        end
      end
      ST_EVICT_CHK: begin
        state_d = (valid_q[pidx] && dirty_q[pidx]) ? ST_EVICT_OUT : ST_UPDATE;
      end
      ST_EVICT_OUT: begin
        if (out_free) begin
          state_d = ST_UPDATE;
        end
      end
      ST_FL_SCAN: begin
        if (ptr_q == n_c) begin
          state_d = ST_FL_DONE;
        end else if (valid_q[pidx] && dirty_q[pidx]) begin
          state_d = ST_FL_OUT;
        end
      end
      ST_FL_OUT: begin
        if (out_free) begin
          state_d = ST_FL_SCAN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Datapath control and response beats.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    ptr_d     = ptr_q;
    hit_d     = hit_q;
    cnt_d     = cnt_q;
    lfsr_d    = lfsr_q;
    valid_d   = valid_q;
    dirty_d   = dirty_q;
    tag_we    = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = req_q.wdata;
    mem_re    = 1'b0;
    mem_raddr = pidx;
    emit      = 1'b0;
    out_d     = out_q;

    case (state_q)
      ST_IDLE: begin
        ptr_d = '0;
      end
      ST_ERROR: begin
        if (out_free) begin
          emit            = 1'b1;
          out_d.kind      = KIND_ERR;
          out_d.out_block = req_q.block_num;
          out_d.out_data  = '0;
          out_d.hit       = 1'b0;
          out_d.last      = 1'b1;
        end
      end
      ST_LOOKUP: begin
        hit_d = hit_found;
        cnt_d = '0;
        if (hit_found) begin
          ptr_d     = N_W'(hit_idx);
          mem_re    = (req_q.cmd == CMD_READ);
          mem_raddr = hit_idx;
        end else if (empty_found) begin
          ptr_d = N_W'(empty_idx);
        end
      end
      ST_MOD: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(LFSR_W - 1)) begin
          ptr_d  = rem_d;
          lfsr_d = lfsr_step(lfsr_q);
        end
      end
      ST_EVICT_CHK: begin
        mem_re = valid_q[pidx] && dirty_q[pidx];
      end
      ST_EVICT_OUT: begin
        if (out_free) begin
          emit            = 1'b1;
          out_d.kind      = KIND_WB;
          out_d.out_block = tag_q[pidx];
          out_d.out_data  = rdata_q;
          out_d.hit       = 1'b0;
          out_d.last      = 1'b0;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          emit            = 1'b1;
          tag_we          = 1'b1;
          mem_we          = 1'b1;
          valid_d[pidx]   = 1'b1;
          out_d.out_block = req_q.block_num;
          out_d.hit       = hit_q;
          out_d.last      = 1'b1;
          if (req_q.cmd == CMD_READ) begin
            // Only a read miss comes this way: fill from the disk, clean.
            mem_wdata      = req_q.disk_data;
            dirty_d[pidx]  = 1'b0;
            out_d.kind     = KIND_READ;
            out_d.out_data = req_q.disk_data;
          end else begin
            mem_wdata      = req_q.wdata;
            dirty_d[pidx]  = 1'b1;
            out_d.kind     = KIND_DONE;
            out_d.out_data = '0;
          end
        end
      end
      ST_READ_OUT: begin
        if (out_free) begin
          emit            = 1'b1;
          out_d.kind      = KIND_READ;
          out_d.out_block = req_q.block_num;
          out_d.out_data  = rdata_q;
          out_d.hit       = 1'b1;
          out_d.last      = 1'b1;
        end
      end
      ST_FL_SCAN: begin
        if (ptr_q != n_c) begin
          if (valid_q[pidx] && dirty_q[pidx]) begin
            mem_re = 1'b1;
          end else begin
            ptr_d = ptr_q + N_W'(1);
          end
        end
      end
      ST_FL_OUT: begin
        if (out_free) begin
          emit            = 1'b1;
          out_d.kind      = KIND_WB;
          out_d.out_block = tag_q[pidx];
          out_d.out_data  = rdata_q;
          out_d.hit       = 1'b0;
          out_d.last      = 1'b0;
          valid_d[pidx]   = 1'b0;
          dirty_d[pidx]   = 1'b0;
          ptr_d           = ptr_q + N_W'(1);
        end
      end
      ST_FL_DONE: begin
        if (out_free) begin
          emit            = 1'b1;
          out_d.kind      = KIND_DONE;
          out_d.out_block = '0;
          out_d.out_data  = '0;
          out_d.hit       = 1'b0;
          out_d.last      = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // A configuration beat to the seed register reloads the LFSR; a zero seed is taken as one.
    if (cfg_acc && (cfg_index_i == CFG_LFSR_SEED)) begin
      lfsr_d = (cfg_data_i[LFSR_W-1:0] == '0) ? LFSR_SEED_RST : cfg_data_i[LFSR_W-1:0];
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      dirty_q     <= '0;
      out_valid_q <= 1'b0;
      ptr_q       <= '0;
      hit_q       <= 1'b0;
      cnt_q       <= '0;
      rem_q       <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      dirty_q     <= dirty_d;
      out_valid_q <= out_valid_d;
      ptr_q       <= ptr_d;
      hit_q       <= hit_d;
      cnt_q       <= cnt_d;
      if (state_q == ST_MOD) begin
        rem_q <= rem_d;
      end else begin
        rem_q <= '0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_i;
    end
    if (emit) begin
      out_q <= out_d;
    end
    if (tag_we) begin
      tag_q[pidx] <= req_q.block_num;
    end
  end

  // Data memory: write at the pointer, registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      data_mem[pidx] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= data_mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------------
  a_dirty_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dirty_q & ~valid_q) == '0)
    else $error("dirty entry without valid bit");

  a_wb_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.kind == KIND_WB) |-> !out_q.last && !out_q.hit)
    else $error("writeback beat marked last or hit");

  a_req_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("accepted request left no work behind");

  a_flush_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FL_OUT |-> valid_q[pidx] && dirty_q[pidx] && (ptr_q < n_c))
    else $error("flush writeback of a clean or unused entry");

  a_victim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EVICT_CHK |-> ptr_q < n_c)
    else $error("victim outside the entries in use");

endmodule
